// File: rtl/rgbpwm_pkg.sv
// Shared types, constants and the brightness curve table for the RGB PWM timer.
// No dependencies; used by rgbpwm_curve, rgbpwm_timer and the top level.
package rgbpwm_pkg;

    localparam int CHANNELS    = 3;
    localparam int COUNT_WIDTH = 16;
    localparam int PIN_COUNT   = 3;
    localparam int REG_WIDTH   = 16;
    localparam int PCT_WIDTH   = 7;
    localparam int CH_WIDTH    = 2;
    localparam int RECIP_WIDTH = 50;
    localparam int RECIP_HALF  = 25;
    localparam int PROD_WIDTH  = REG_WIDTH + RECIP_HALF;

    localparam logic [PCT_WIDTH-1:0] FULL_PERCENT = 7'd100;
    localparam logic [REG_WIDTH-1:0] PRESCALE_RESET = 16'd1;
    localparam logic [REG_WIDTH-1:0] PERIOD_RESET   = 16'd16000;

    localparam logic [32:0] COUNT_MAX_WIDE = (33'd1 << COUNT_WIDTH) - 33'd1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [RECIP_WIDTH-1:0] recip_t;
    typedef recip_t recip_table_t [0:100];

    typedef enum logic
    {
        REQ_TICK = 1'b0,
        REQ_SET  = 1'b1
    } req_t;

    typedef enum logic
    {
        CFG_PRESCALE = 1'b0,
        CFG_PERIOD   = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic                valid;
        req_t                req;
        logic [CH_WIDTH-1:0] ch;
    } op_t;

    typedef struct packed
    {
        logic                 update_event;
        logic [PIN_COUNT-1:0] pins;
    } result_t;

    // ceil(ratio * 2^50), ratio = A / (2^32 + F(d)), F(d) ~ exp(-0.1*d) in Q32
    function automatic recip_t recip_for(int unsigned p);
        logic [63:0]  f;
        logic [63:0]  a;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] rem;
        logic [127:0] q;
        int unsigned  d;
        f = 64'h1_0000_0000;
        d = (p >= 60) ? (p - 60) : (60 - p);
        for (int unsigned i = 0; i < d; i++)
        begin
            f = (f * 64'd3886247119) >> 32;
        end
        a   = (p >= 60) ? 64'h1_0000_0000 : f;
        den = 128'(f) + 128'h1_0000_0000;
        num = 128'(a) << RECIP_WIDTH;
        rem = '0;
        q   = '0;
        for (int i = 127; i >= 0; i--)
        begin
            rem = {rem[126:0], num[i]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        if (rem != '0)
        begin
            q = q + 128'd1;
        end
        return q[RECIP_WIDTH-1:0];
    endfunction

    function automatic recip_table_t build_recip_table();
        recip_table_t t;
        t[0] = '0;
        for (int unsigned p = 1; p <= 100; p++)
        begin
            t[p] = recip_for(p);
        end
        return t;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

    function automatic count_t sat_count(logic [REG_WIDTH-1:0] v);
        if (33'(v) > COUNT_MAX_WIDE)
        begin
            return COUNT_MAX_WIDE[COUNT_WIDTH-1:0];
        end
        return count_t'(v);
    endfunction

endpackage

// File: rtl/rgb_led_pwm_sigmoid_timer_unit.sv
// Top level of the three-channel RGB LED PWM timer with sigmoid brightness curve.
// Depends on rgbpwm_pkg, rgbpwm_curve and rgbpwm_timer.
//
// One transaction is accepted every clock while the output side keeps up. Each
// passes four registers (input register, curve table lookup, two 16x25 partial
// products, then the final add, timer update and output register), in that order.
// A tick advances the prescaler and counter; a set request turns a percent into a
// compare value that goes to the channel's preload register and becomes active at
// the next counter wrap. Results carry active-low pin levels and an update flag.
// Write prescale and period only while the block is idle.
module rgb_led_pwm_sigmoid_timer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [1:0] channel, [8:2] brightness, rest zero
    input  logic        s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [0] red_pin, [1] green_pin, [2] blue_pin,
                                    // [3] update_event, rest zero
);

    logic [rgbpwm_pkg::REG_WIDTH-1:0] prescale_reg;
    logic [rgbpwm_pkg::REG_WIDTH-1:0] period_reg;
    rgbpwm_pkg::op_t                  s1_op_reg;
    logic [rgbpwm_pkg::PCT_WIDTH-1:0] s1_pct_reg;
    rgbpwm_pkg::op_t                  s3_op;
    logic [rgbpwm_pkg::REG_WIDTH-1:0] s3_cmp;
    rgbpwm_pkg::result_t              res;
    logic                             m_valid_reg;
    rgbpwm_pkg::result_t              m_res_reg;
    logic                             advance;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= rgbpwm_pkg::PRESCALE_RESET;
            period_reg   <= rgbpwm_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (rgbpwm_pkg::cfg_index_t'(cfg_index))
                rgbpwm_pkg::CFG_PRESCALE: prescale_reg <= cfg_data;
                rgbpwm_pkg::CFG_PERIOD:   period_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_op_reg.valid <= s_tvalid;
            s1_op_reg.req   <= rgbpwm_pkg::req_t'(s_tuser);
            s1_op_reg.ch    <= s_tdata[1:0];
            m_valid_reg     <= s3_op.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pct_reg <= s_tdata[8:2];
            m_res_reg  <= res;
        end
    end

    rgbpwm_curve u_curve
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .op_in  (s1_op_reg),
        .pct_in (s1_pct_reg),
        .period (period_reg),
        .op_out (s3_op),
        .cmp    (s3_cmp)
    );

    rgbpwm_timer u_timer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .op       (s3_op),
        .cmp      (s3_cmp),
        .prescale (prescale_reg),
        .period   (period_reg),
        .res      (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_res_reg};

endmodule

// File: rtl/rgbpwm_curve.sv
// Brightness-to-compare pipeline: curve table lookup, then two partial products.
// Depends on rgbpwm_pkg.
module rgbpwm_curve
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  rgbpwm_pkg::op_t                    op_in,
    input  logic [rgbpwm_pkg::PCT_WIDTH-1:0]   pct_in,
    input  logic [rgbpwm_pkg::REG_WIDTH-1:0]   period,
    output rgbpwm_pkg::op_t                    op_out,
    output logic [rgbpwm_pkg::REG_WIDTH-1:0]   cmp
);

    rgbpwm_pkg::op_t                         s2_op_reg;
    rgbpwm_pkg::recip_t                      s2_m_reg;
    rgbpwm_pkg::op_t                         s3_op_reg;
    logic [rgbpwm_pkg::PROD_WIDTH-1:0]       s3_lo_reg;
    logic [rgbpwm_pkg::PROD_WIDTH-1:0]       s3_hi_reg;

    logic [rgbpwm_pkg::PCT_WIDTH-1:0]        pct_sat;
    logic [rgbpwm_pkg::PROD_WIDTH:0]         sum;

    assign pct_sat = (pct_in > rgbpwm_pkg::FULL_PERCENT) ? rgbpwm_pkg::FULL_PERCENT : pct_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_op_reg <= '0;
            s3_op_reg <= '0;
        end
        else if (en)
        begin
            s2_op_reg <= op_in;
            s3_op_reg <= s2_op_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_m_reg  <= rgbpwm_pkg::RECIP_TABLE[pct_sat];
            s3_lo_reg <= period * s2_m_reg[rgbpwm_pkg::RECIP_HALF-1:0];
            s3_hi_reg <= period * s2_m_reg[rgbpwm_pkg::RECIP_WIDTH-1:rgbpwm_pkg::RECIP_HALF];
        end
    end

    // floor((hi*2^25 + lo) / 2^50)
    assign sum = {1'b0, s3_hi_reg}
               + (rgbpwm_pkg::PROD_WIDTH+1)'(s3_lo_reg[rgbpwm_pkg::PROD_WIDTH-1:
                                                       rgbpwm_pkg::RECIP_HALF]);
    assign cmp    = sum[rgbpwm_pkg::RECIP_HALF+rgbpwm_pkg::REG_WIDTH-1:rgbpwm_pkg::RECIP_HALF];
    assign op_out = s3_op_reg;

endmodule

// File: rtl/rgbpwm_timer.sv
// Prescaler, main counter, preload/active compare registers and pin compare.
// Depends on rgbpwm_pkg.
module rgbpwm_timer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  rgbpwm_pkg::op_t                  op,
    input  logic [rgbpwm_pkg::REG_WIDTH-1:0] cmp,
    input  logic [rgbpwm_pkg::REG_WIDTH-1:0] prescale,
    input  logic [rgbpwm_pkg::REG_WIDTH-1:0] period,
    output rgbpwm_pkg::result_t              res
);

    logic [rgbpwm_pkg::REG_WIDTH-1:0] pc_reg;
    logic [rgbpwm_pkg::REG_WIDTH-1:0] pc_next;
    rgbpwm_pkg::count_t               main_reg;
    rgbpwm_pkg::count_t               main_next;
    rgbpwm_pkg::count_t               active_reg  [rgbpwm_pkg::CHANNELS];
    rgbpwm_pkg::count_t               active_next [rgbpwm_pkg::CHANNELS];
    rgbpwm_pkg::count_t               preload_reg [rgbpwm_pkg::CHANNELS];
    rgbpwm_pkg::count_t               preload_next[rgbpwm_pkg::CHANNELS];
    rgbpwm_pkg::count_t               top;
    rgbpwm_pkg::count_t               cmp_sat;
    logic                             upd;

    assign top     = rgbpwm_pkg::sat_count(period);
    assign cmp_sat = rgbpwm_pkg::sat_count(cmp);

    always_comb
    begin
        pc_next      = pc_reg;
        main_next    = main_reg;
        active_next  = active_reg;
        preload_next = preload_reg;
        upd          = 1'b0;
        if (op.valid)
        begin
            if (op.req == rgbpwm_pkg::REQ_SET)
            begin
                for (int i = 0; i < rgbpwm_pkg::CHANNELS; i++)
                begin
                    if (op.ch == rgbpwm_pkg::CH_WIDTH'(i))
                    begin
                        preload_next[i] = cmp_sat;
                    end
                end
            end
            else if (pc_reg >= prescale)
            begin
                pc_next = '0;
                if (main_reg >= top)
                begin
                    main_next   = '0;
                    upd         = 1'b1;
                    active_next = preload_reg;
                end
                else
                begin
                    main_next = main_reg + 1'b1;
                end
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            main_reg <= '0;
            for (int i = 0; i < rgbpwm_pkg::CHANNELS; i++)
            begin
                active_reg[i]  <= '0;
                preload_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            pc_reg      <= pc_next;
            main_reg    <= main_next;
            active_reg  <= active_next;
            preload_reg <= preload_next;
        end
    end

    // inverted PWM mode 1: low while count is below compare
    for (genvar g = 0; g < rgbpwm_pkg::PIN_COUNT; g++)
    begin : g_pin
        if (g < rgbpwm_pkg::CHANNELS)
        begin : g_on
            assign res.pins[g] = !(main_next < active_next[g]);
        end
        else
        begin : g_off
            assign res.pins[g] = 1'b1;
        end
    end

    assign res.update_event = upd;

endmodule
